// ----- design/flag_byte_word_packer_defines.svh -----
// Assertion macros shared by the flag byte word packer modules.
`ifndef FLAG_BYTE_WORD_PACKER_DEFINES_SVH
`define FLAG_BYTE_WORD_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold.
`define FBWP_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("fbwp: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define FBWP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbwp: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define FBWP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbwp: next-cycle implication failed");

`else

`define FBWP_ASSERT_NEVER(lbl, expr)
`define FBWP_ASSERT_IMP(lbl, ante, cons)
`define FBWP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- design/fbwp_pkg.sv -----
// Shared types and constants for the flag byte word packer.
`timescale 1ns / 1ps

package fbwp_pkg;

	localparam int GROUP_SIZE_DEF = 8;
	localparam int LEN_W          = 12;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef struct packed {
		logic [15:0] word_in;
		logic        word_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             is_length;
		logic [LEN_W-1:0] kept_length;
		logic             out_last;
	} out_word_t;

	// Source of the byte produced by an emit command.
	typedef enum logic [2:0] {
		SRC_HDR,
		SRC_FLAG,
		SRC_LO,
		SRC_HI,
		SRC_LEN
	} src_t;

	typedef struct packed {
		logic load;        // store the accepted word
		logic emit;        // load the output register
		src_t src;
		logic word_next;   // advance to next buffered word
		logic group_done;  // group fully emitted, clear it
	} cmd_t;

	typedef struct packed {
		logic hdr_done;
		logic hdr_last;    // last header byte is up next
		logic flush_now;   // incoming word closes a group
		logic flush_q;     // accepted word closed a group
		logic last_q;      // accepted word ended the stream
		logic hi_nz;       // current word has a nonzero high byte
		logic word_end;    // current word is the last in the group
		logic out_free;    // output register can take a word
	} sts_t;

endpackage

// ----- design/fbwp_ctrl.sv -----
// Sequencing state machine for the flag byte word packer.
`timescale 1ns / 1ps
`include "flag_byte_word_packer_defines.svh"

module fbwp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          cfg_ready,
	input  fbwp_pkg::sts_t sts,
	output fbwp_pkg::cmd_t cmd
);
	import fbwp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_FLAG,
		S_LO,
		S_HI,
		S_LEN
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		cmd.src   = SRC_HDR;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.hdr_done) begin
						state_nxt = S_HDR;
					end else if (sts.flush_now) begin
						state_nxt = S_FLAG;
					end
				end
			end
			S_HDR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_HDR;
					if (sts.hdr_last) begin
						state_nxt = sts.flush_q ? S_FLAG : S_IDLE;
					end
				end
			end
			S_FLAG: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.src   = SRC_FLAG;
					state_nxt = S_LO;
				end
			end
			S_LO, S_HI: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = (state_q == S_LO) ? SRC_LO : SRC_HI;
					if (state_q == S_LO && sts.hi_nz) begin
						state_nxt = S_HI;
					end else if (sts.word_end) begin
						cmd.group_done = 1'b1;
						state_nxt      = sts.last_q ? S_LEN : S_IDLE;
					end else begin
						cmd.word_next = 1'b1;
						state_nxt     = S_LO;
					end
				end
			end
			S_LEN: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.src   = SRC_LEN;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	`FBWP_ASSERT_NXT(a_hdr_first, cmd.load && !sts.hdr_done, state_q == S_HDR)
	`FBWP_ASSERT_IMP(a_len_only_last, state_q == S_LEN, sts.last_q)
	`FBWP_ASSERT_IMP(a_hi_needs_nz, state_q == S_HI, sts.hi_nz)
	`FBWP_ASSERT_NXT(a_flag_then_lo, cmd.emit && cmd.src == SRC_FLAG, state_q == S_LO)

endmodule

// ----- design/fbwp_dp.sv -----
// Datapath of the flag byte word packer: group buffer, counters, output register.
`timescale 1ns / 1ps
`include "flag_byte_word_packer_defines.svh"

module fbwp_dp #(
	parameter int GROUP_SIZE = fbwp_pkg::GROUP_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fbwp_pkg::in_word_t in_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [31:0]        cfg_data,
	input  logic               out_stall,
	output logic               out_valid,
	output fbwp_pkg::out_word_t out_data,
	input  fbwp_pkg::cmd_t     cmd,
	output fbwp_pkg::sts_t     sts
);
	import fbwp_pkg::*;

	localparam int IDX_W = $clog2(GROUP_SIZE);
	localparam int CNT_W = $clog2(GROUP_SIZE + 1);

	logic [15:0]           buf_q [GROUP_SIZE];
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [GROUP_SIZE-1:0] flag_q;
	logic [1:0]            hdr_idx_q;
	logic                  hdr_done_q;
	logic                  flush_q;
	logic                  last_q;
	logic [LEN_W-1:0]      bytes_q;
	logic [LEN_W-1:0]      lnz_q;
	logic [31:0]           magic_q;
	logic                  out_valid_q;
	out_word_t             out_data_q;

	logic [15:0]      cur_word;
	logic [31:0]      hdr_shift;
	logic [7:0]       byte_val;
	logic [LEN_W-1:0] bytes_nxt;
	out_word_t        out_nxt;

	assign cur_word  = buf_q[idx_q];
	// MSB first: byte 0 of the header is magic[31:24]
	assign hdr_shift = magic_q >> {~hdr_idx_q, 3'b000};
	assign bytes_nxt = (bytes_q == LEN_MAX) ? bytes_q : bytes_q + LEN_W'(1);

	always_comb begin
		case (cmd.src)
			SRC_HDR:  byte_val = hdr_shift[7:0];
			SRC_FLAG: byte_val = 8'(flag_q);
			SRC_LO:   byte_val = cur_word[7:0];
			SRC_HI:   byte_val = cur_word[15:8];
			default:  byte_val = 8'h00;
		endcase
		out_nxt          = '0;
		out_nxt.out_byte = byte_val;
		if (cmd.src == SRC_LEN) begin
			out_nxt.is_length   = 1'b1;
			out_nxt.kept_length = lnz_q;
			out_nxt.out_last    = 1'b1;
		end
	end

	// group buffer: written only for words of the current group
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[IDX_W-1:0]] <= in_data.word_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= out_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			flag_q      <= '0;
			hdr_idx_q   <= '0;
			hdr_done_q  <= 1'b0;
			flush_q     <= 1'b0;
			last_q      <= 1'b0;
			bytes_q     <= '0;
			lnz_q       <= '0;
			magic_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				magic_q <= cfg_data;
			end
			if (cmd.load) begin
				cnt_q                     <= cnt_q + CNT_W'(1);
				flag_q[cnt_q[IDX_W-1:0]]  <= |in_data.word_in[15:8];
				flush_q                   <= sts.flush_now;
				last_q                    <= in_data.word_last;
			end
			if (cmd.word_next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.group_done) begin
				cnt_q  <= '0;
				idx_q  <= '0;
				flag_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (cmd.src == SRC_LEN) begin
					hdr_done_q <= 1'b0;
					bytes_q    <= '0;
					lnz_q      <= '0;
				end else begin
					bytes_q <= bytes_nxt;
					if (byte_val != 8'h00) begin
						lnz_q <= bytes_nxt;
					end
				end
				if (cmd.src == SRC_HDR) begin
					hdr_idx_q <= hdr_idx_q + 2'd1;
					if (hdr_idx_q == 2'd3) begin
						hdr_done_q <= 1'b1;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts           = '0;
		sts.hdr_done  = hdr_done_q;
		sts.hdr_last  = (hdr_idx_q == 2'd3);
		sts.flush_now = (cnt_q == CNT_W'(GROUP_SIZE - 1)) || in_data.word_last;
		sts.flush_q   = flush_q;
		sts.last_q    = last_q;
		sts.hi_nz     = |cur_word[15:8];
		sts.word_end  = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`FBWP_ASSERT_NEVER(a_cnt_range, cnt_q > CNT_W'(GROUP_SIZE))
	`FBWP_ASSERT_NEVER(a_lnz_le_bytes, lnz_q > bytes_q)

endmodule

// ----- design/flag_byte_word_packer.sv -----
// Top level of the flag byte word packer: controller plus datapath.
`timescale 1ns / 1ps

//  channel | dir | handshake            | word
//  --------+-----+----------------------+---------------------------------------------
//  in      | in  | in_valid / in_stall  | in_data: word_in[15:0], word_last
//  out     | out | out_valid / out_stall| out_data: out_byte, is_length, kept_length,
//          |     |                      |           out_last
//  cfg     | in  | cfg_valid / cfg_ready| cfg_data[31:0] -> magic_word
//
// Flow: a word that produces no output is accepted without leaving idle, and the next
//   word can follow right away. A word that produces output is accepted first, then
//   its bytes leave one by one through the single output register, held by out_stall
//   (up to 4 header + 1 flag + 16 data + 1 length words at the default GROUP_SIZE).
// Reset: arst_n clears the sequencer, counters, magic word and output valid;
//   the GROUP_SIZE-entry group buffer is not cleared, only written entries are read.
// Stalls: out_stall holds the output register and freezes the sequencer;
//   in_stall is high whenever the sequencer is busy emitting.
// Config: cfg_ready is high only while idle.

module flag_byte_word_packer #(
	parameter int GROUP_SIZE = fbwp_pkg::GROUP_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fbwp_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output fbwp_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [31:0]         cfg_data
);
	import fbwp_pkg::*;

	cmd_t cmd;  // controller -> datapath
	sts_t sts;  // datapath -> controller

	// sequencer: header, flag byte, low/high bytes, closing length word
	fbwp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// buffer, flag bits, byte counters and the output register
	fbwp_dp #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
